>>> design/mgn_pkg.sv
// ----------------------------------------------------------------------------
// mgn_pkg
// Shared types and constants of the maximum-based gray normaliser.
// ----------------------------------------------------------------------------
package mgn_pkg;

  localparam int PIXEL_W     = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PIXEL_W-1:0] FULL_SCALE = '1;

  // Pass codes carried on cmd.
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_SCALE   = 1'b1;

  // One scale job: the pixel and the maximum that was in force when it arrived.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [PIXEL_W-1:0] max_value;
  } job_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

>>> design/mgn_front.sv
// ----------------------------------------------------------------------------
// mgn_front
// Takes input items, keeps the running maximum and queues scale jobs.
// ----------------------------------------------------------------------------
module mgn_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        cmd,
  input  logic                        frame_start,
  input  logic [mgn_pkg::PIXEL_W-1:0] pixel,
  input  logic                        q_full,
  output logic                        q_push,
  output mgn_pkg::job_t               q_data
);
  import mgn_pkg::*;

  logic [PIXEL_W-1:0] running_max;
  logic [PIXEL_W-1:0] running_max_next;
  logic [PIXEL_W-1:0] base_max;
  logic               accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && (cmd == CMD_SCALE);

  assign q_data.pixel     = pixel;
  assign q_data.max_value = running_max;

  always_comb begin
    base_max         = frame_start ? PIXEL_W'(1) : running_max;
    running_max_next = running_max;
    if (accept && (cmd == CMD_MEASURE)) begin
      running_max_next = (pixel > base_max) ? pixel : base_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= PIXEL_W'(1);
    end else begin
      running_max <= running_max_next;
    end
  end

endmodule

>>> design/mgn_fifo.sv
// ----------------------------------------------------------------------------
// mgn_fifo
// Short register queue of scale jobs between the front and the divider.
// ----------------------------------------------------------------------------
module mgn_fifo #(
  parameter int DEPTH = mgn_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mgn_pkg::job_t wr_data,
  output logic          full,
  input  logic          pop,
  output mgn_pkg::job_t rd_data,
  output logic          valid
);
  import mgn_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/mgn_divider.sv
// ----------------------------------------------------------------------------
// mgn_divider
// Restoring divider that forms round(pixel * 65535 / max), one quotient bit
// per cycle, and holds the result until it is popped.
// ----------------------------------------------------------------------------
module mgn_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  mgn_pkg::job_t               job,
  output logic                        job_take,
  output logic                        empty,
  input  logic                        pop,
  output logic [mgn_pkg::PIXEL_W-1:0] scaled_pixel
);
  import mgn_pkg::*;

  localparam int NUM_W = 2 * PIXEL_W + 2;
  localparam int REM_W = PIXEL_W + 2;
  localparam int DEN_W = PIXEL_W + 1;
  localparam int CNT_W = $clog2(PIXEL_W + 1);

  div_state_t         state;
  div_state_t         state_next;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem_next;
  logic [PIXEL_W-1:0] num_lo;
  logic [PIXEL_W-1:0] num_lo_next;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   den_next;
  logic [PIXEL_W-1:0] quo;
  logic [PIXEL_W-1:0] quo_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [NUM_W-1:0]   numer;
  logic [REM_W-1:0]   trial;
  logic               fits;

  assign scaled_pixel = quo;

  // 2*p*65535 + m, written as (p << 17) - (p << 1) + m.
  assign numer = (NUM_W'(job.pixel) << (PIXEL_W + 1)) - (NUM_W'(job.pixel) << 1)
               + NUM_W'(job.max_value);
  assign trial = {rem[REM_W-2:0], num_lo[PIXEL_W-1]};
  assign fits  = (trial >= REM_W'(den));

  always_comb begin
    state_next  = state;
    rem_next    = rem;
    num_lo_next = num_lo;
    den_next    = den;
    quo_next    = quo;
    cnt_next    = cnt;
    job_take    = 1'b0;
    empty       = 1'b1;
    case (state)
      DIV_IDLE: begin
        if (job_valid) begin
          job_take = 1'b1;
          if (job.pixel > job.max_value) begin
            // A pixel above the measured maximum saturates at full scale.
            quo_next   = FULL_SCALE;
            state_next = DIV_DONE;
          end else begin
            // With pixel <= max the quotient fits in 16 bits, so the upper
            // numerator bits already sit below the divisor.
            rem_next    = numer[NUM_W-1:PIXEL_W];
            num_lo_next = numer[PIXEL_W-1:0];
            den_next    = {job.max_value, 1'b0};
            cnt_next    = '0;
            state_next  = DIV_RUN;
          end
        end
      end
      DIV_RUN: begin
        rem_next    = fits ? trial - REM_W'(den) : trial;
        num_lo_next = {num_lo[PIXEL_W-2:0], 1'b0};
        quo_next    = {quo[PIXEL_W-2:0], fits};
        cnt_next    = cnt + 1'b1;
        if (cnt == CNT_W'(PIXEL_W - 1)) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        empty = 1'b0;
        if (pop) begin
          state_next = DIV_IDLE;
        end
      end
      default: begin
        state_next = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem    <= rem_next;
    num_lo <= num_lo_next;
    den    <= den_next;
    quo    <= quo_next;
    cnt    <= cnt_next;
  end

endmodule

>>> design/max_gray_normalizer.sv
// ----------------------------------------------------------------------------
// max_gray_normalizer
// Stretches 16-bit gray pixels so that the frame maximum maps to 65535.
// ----------------------------------------------------------------------------
// Each frame is streamed twice. A measure pixel (cmd 0) is taken in one per
// clock whenever full is low and produces no result; frame_start on it resets
// the maximum to 1 first. A scale pixel (cmd 1) is queued together with the
// maximum in force at that moment, so later measure pixels do not disturb it,
// and yields round(pixel * 65535 / max) with ties going up, saturated at
// 65535. Scale results come from a restoring divider that produces one
// quotient bit per clock: a scale pixel occupies it for a load step, 16
// quotient steps and a hand-over, or load and hand-over if it saturates. A
// queue of QueueDepth jobs in front of the divider lets measure and scale
// pixels be pushed while the divider is busy or a result waits to be popped.
module max_gray_normalizer #(
  parameter int QueueDepth = mgn_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        cmd,
  input  logic                        frame_start,
  input  logic [mgn_pkg::PIXEL_W-1:0] pixel,
  output logic                        empty,
  input  logic                        pop,
  output logic [mgn_pkg::PIXEL_W-1:0] scaled_pixel
);
  import mgn_pkg::*;

  logic q_full;
  logic q_push;
  logic q_valid;
  logic q_pop;
  job_t q_wr_data;
  job_t q_rd_data;

  mgn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .frame_start (frame_start),
    .pixel       (pixel),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  mgn_fifo #(
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .valid   (q_valid)
  );

  mgn_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_valid),
    .job          (q_rd_data),
    .job_take     (q_pop),
    .empty        (empty),
    .pop          (pop),
    .scaled_pixel (scaled_pixel)
  );

endmodule

>>> design/mgn_checker.sv
// ----------------------------------------------------------------------------
// mgn_checker
// Port-level checks of the normaliser, bound to the top level.
// ----------------------------------------------------------------------------
module mgn_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        push,
  input logic                        full,
  input logic                        cmd,
  input logic                        empty,
  input logic                        pop,
  input logic [mgn_pkg::PIXEL_W-1:0] scaled_pixel
);
  import mgn_pkg::*;

  // Scale pixels taken in whose results have not yet been transferred out.
  logic [7:0] pending;
  logic       scale_in;
  logic       result_out;

  assign scale_in   = push && !full && (cmd == CMD_SCALE);
  assign result_out = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (scale_in && !result_out) begin
      pending <= pending + 1'b1;
    end else if (result_out && !scale_in) begin
      pending <= pending - 1'b1;
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown straight after reset");

  a_not_full_after_reset: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked straight after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(scaled_pixel)))
    else $error("waiting result changed or vanished");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != '0))
    else $error("result shown without a scale pixel behind it");

  a_no_measure_result: assert property (@(posedge clk) disable iff (rst)
    (pending == '0) |-> empty)
    else $error("result shown while no scale transfer is outstanding");

endmodule

bind max_gray_normalizer mgn_checker u_mgn_checker (.*);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the maximum-based gray normaliser. A built-in
// predictor follows the running maximum over measure pixels and works out the
// stretched value of every scale pixel. Each popped result is checked against
// the oldest prediction. Directed cases come first, then random two-pass
// frames, broken frames and noise, under random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mgn_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int TAIL_CYCLES  = 40;
  localparam int ITEM_TARGET  = 920;

  logic               clk;
  logic               rst         = 1'b1;
  logic               push        = 1'b0;
  logic               full;
  logic               cmd         = CMD_MEASURE;
  logic               frame_start = 1'b0;
  logic [PIXEL_W-1:0] pixel       = '0;
  logic               empty;
  logic               pop         = 1'b0;
  logic [PIXEL_W-1:0] scaled_pixel;

  // Predictor state and the stretched values still to be popped.
  logic [PIXEL_W-1:0] peak_level = 16'd1;
  logic [PIXEL_W-1:0] expected_pixels[$];

  int  error_count = 0;
  int  items_sent  = 0;
  int  burst_left  = 0;
  bit  pace_on     = 1'b0;
  bit  rx_stall_on = 1'b0;
  bit  rx_hold     = 1'b0;
  int  rx_left     = 0;

  max_gray_normalizer u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .frame_start  (frame_start),
    .pixel        (pixel),
    .empty        (empty),
    .pop          (pop),
    .scaled_pixel (scaled_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // Rounded stretch with ties going up, saturated at full scale.
  function automatic logic [PIXEL_W-1:0] stretch_pixel(input logic [PIXEL_W-1:0] px,
                                                       input logic [PIXEL_W-1:0] peak);
    logic [39:0] num;
    logic [39:0] den;
    logic [39:0] quo;
    logic [39:0] m;
    m   = (peak == 0) ? 40'd1 : 40'(peak);
    num = 40'd2 * 40'(px) * 40'(FULL_SCALE) + m;
    den = 40'd2 * m;
    quo = num / den;
    if (quo > 40'(FULL_SCALE)) begin
      return FULL_SCALE;
    end
    return quo[PIXEL_W-1:0];
  endfunction

  // Offers one pixel and waits for its transfer. Push is left high so that the
  // next pixel can follow on the very next clock.
  task automatic send_pixel(input logic op, input logic fs, input logic [PIXEL_W-1:0] px);
    int gap;
    if (pace_on && burst_left == 0) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    push        <= 1'b1;
    cmd         <= op;
    frame_start <= fs;
    pixel       <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    if (op == CMD_MEASURE) begin
      if (fs) begin
        peak_level = 16'd1;
      end
      if (px > peak_level) begin
        peak_level = px;
      end
    end else begin
      expected_pixels = {expected_pixels, stretch_pixel(px, peak_level)};
    end
    items_sent++;
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Receiver: alternating runs of popping and stalling of random length.
  always @(posedge clk) begin
    if (!rx_stall_on) begin
      pop <= 1'b1;
    end else if (rx_left == 0) begin
      rx_hold = !rx_hold;
      rx_left = rx_hold ? $urandom_range(1, 40) : $urandom_range(1, 10);
      pop <= !rx_hold;
    end else begin
      rx_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d", $time, scaled_pixel);
        error_count++;
      end else if (scaled_pixel !== expected_pixels[0]) begin
        $display("%0t: scaled_pixel expected %0d, got %0d", $time, expected_pixels[0],
                 scaled_pixel);
        error_count++;
        void'(expected_pixels.pop_front());
      end else begin
        void'(expected_pixels.pop_front());
      end
    end
  end

  // Scale pixels before any measure pass use the reset maximum of 1.
  task automatic test_reset_peak();
    send_pixel(CMD_SCALE, 1'b0, 16'd0);
    send_pixel(CMD_SCALE, 1'b0, 16'd1);
    send_pixel(CMD_SCALE, 1'b0, 16'hFFFF);
  endtask

  task automatic test_extremes();
    send_pixel(CMD_MEASURE, 1'b1, 16'd0);
    send_pixel(CMD_SCALE, 1'b0, 16'd1);
    send_pixel(CMD_MEASURE, 1'b0, 16'hFFFF);
    send_pixel(CMD_SCALE, 1'b0, 16'd0);
    send_pixel(CMD_SCALE, 1'b0, 16'hFFFF);
    send_pixel(CMD_SCALE, 1'b0, 16'h8000);
    send_pixel(CMD_SCALE, 1'b0, 16'h5555);
    send_pixel(CMD_SCALE, 1'b0, 16'hAAAA);
  endtask

  // A maximum of 2 gives an exact half; small maxima also show saturation.
  task automatic test_rounding();
    send_pixel(CMD_MEASURE, 1'b1, 16'd2);
    send_pixel(CMD_SCALE, 1'b0, 16'd1);
    send_pixel(CMD_MEASURE, 1'b1, 16'd3);
    send_pixel(CMD_SCALE, 1'b0, 16'd1);
    send_pixel(CMD_SCALE, 1'b0, 16'd2);
    send_pixel(CMD_SCALE, 1'b0, 16'd4);
  endtask

  // Frame start on a scale pixel must leave the maximum alone.
  task automatic test_scale_frame_start();
    send_pixel(CMD_SCALE, 1'b1, 16'd3);
    send_pixel(CMD_SCALE, 1'b0, 16'd2);
  endtask

  task automatic run_frame(input int n, input bit clean);
    logic [PIXEL_W-1:0] vals[$];
    logic [PIXEL_W-1:0] mask;
    logic [PIXEL_W-1:0] v;
    logic               fs;
    case ($urandom_range(3))
      0: mask = 16'hFFFF;
      1: mask = 16'h00FF;
      2: mask = 16'h0007;
      default: mask = 16'($urandom);
    endcase
    for (int i = 0; i < n; i++) begin
      v  = 16'($urandom) & mask;
      fs = (i == 0) ? (clean ? 1'b1 : 1'($urandom_range(1))) : 1'b0;
      if (!clean && $urandom_range(5) == 0) begin
        fs = 1'b1;
      end
      vals = {vals, v};
      send_pixel(CMD_MEASURE, fs, v);
    end
    foreach (vals[i]) begin
      if (clean) begin
        send_pixel(CMD_SCALE, 1'b0, vals[i]);
      end else if ($urandom_range(3) == 0) begin
        send_pixel(CMD_SCALE, 1'($urandom_range(1)), 16'($urandom));
      end else begin
        send_pixel(CMD_SCALE, 1'($urandom_range(1)), vals[i]);
      end
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_pixel(1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom));
    end
  endtask

  task automatic test_random_frames();
    while (items_sent < ITEM_TARGET) begin
      pace_on     = ($urandom_range(3) != 0);
      rx_stall_on = ($urandom_range(3) != 0);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: run_frame($urandom_range(1, 20), 1'b1);
        6, 7:             run_frame($urandom_range(1, 20), 1'b0);
        8:                send_noise($urandom_range(1, 10));
        default:          wait_for_drain();
      endcase
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_peak();
    test_extremes();
    rx_stall_on = 1'b1;
    test_rounding();
    test_scale_frame_start();
    wait_for_drain();
    test_random_frames();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
